// File: src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check, reset masks the check
`define CHK_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("%m: property failed");

// value must stay unchanged in the cycle after cond
`define CHK_STABLE(name, clk, rst_n, cond, sig) \
	name: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
	else $error("%m: value changed while held");

`endif

// File: src/brfp_pkg.sv
`default_nettype none
package brfp_pkg;

	localparam int DEPTH_DEFAULT = 256;

	localparam int CMD_W  = 3;
	localparam int DATA_W = 8;
	localparam int IDX_W  = 8;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 8;
	localparam int SIZE_W = 9;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 3'd0,
		CMD_READ  = 3'd1,
		CMD_PEEK  = 3'd2,
		CMD_QUERY = 3'd3,
		CMD_CLEAR = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_BAD_INDEX = 2'd3
	} stat_t;

endpackage
`default_nettype wire

// File: src/brfp_ram.sv
`default_nettype none
module brfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: src/byte_ring_fifo_with_peek_top.sv
// byte ring buffer, one slot kept empty, with peek at an offset from the oldest byte
//
// command channel: command, write_data, peek_index under cmd_valid / cmd_stall.
// response channel: status, read_data, data_count, free_count, data_arrived_event
// under rsp_valid / rsp_stall. every command gives exactly one response beat.
// buffer_size is written through cfg_write_en; the write also clears both
// pointers and the first-data notice. write it only while no command is in flight.
//
// throughput: one command per cycle unless the response side stalls. pointers update
// in the cycle a command is taken and the byte store is a single synchronous ram with
// one read and one write port, so back-to-back commands never collide on an entry.
// the edge that takes a command starts the ram read and loads the stage in front of
// the output register, which loads from that stage when it may move on.
// a stalled response holds the output register and the stage behind it; the
// command channel stalls only when both are full.
// reset clears the pointers, the notice flag and the pipeline valids and sets
// the ring size to 256; the byte store is not cleared and needs no clearing pass.
`default_nettype none
module byte_ring_fifo_with_peek_top #(
	parameter int DEPTH = brfp_pkg::DEPTH_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write_en,
	input  wire logic [brfp_pkg::SIZE_W-1:0]   buffer_size,
	input  wire logic                          cmd_valid,
	output logic                               cmd_stall,
	input  wire logic [brfp_pkg::CMD_W-1:0]    command,
	input  wire logic [brfp_pkg::DATA_W-1:0]   write_data,
	input  wire logic [brfp_pkg::IDX_W-1:0]    peek_index,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic [brfp_pkg::STAT_W-1:0]        status,
	output logic [brfp_pkg::DATA_W-1:0]        read_data,
	output logic [brfp_pkg::CNT_W-1:0]         data_count,
	output logic [brfp_pkg::CNT_W-1:0]         free_count,
	output logic                               data_arrived_event
);

	import brfp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LEN_W = (PTR_W + 1 > SIZE_W) ? PTR_W + 1 : SIZE_W;
	localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(DEPTH);

	logic [SIZE_W-1:0] size_q;
	logic [PTR_W-1:0]  wp_q, rp_q;
	logic              notice_q;

	logic             valid_s1;
	stat_t            status_s1;
	logic             rd_sel_s1;
	logic [CNT_W-1:0] count_s1, free_s1;
	logic             event_s1;

	logic              rsp_valid_q;
	stat_t             status_q;
	logic [DATA_W-1:0] read_data_q;
	logic [CNT_W-1:0]  count_q, free_q;
	logic              event_q;

	logic [DATA_W-1:0] ram_rdata;

	logic             adv_s1, accept;
	logic [LEN_W-1:0] len, bs_ext, wp_ext, rp_ext, wp_inc, wp_wrap, rp_inc, rp_wrap;
	logic [LEN_W-1:0] cnt_now, cnt_next, peek_sum, peek_addr, wp_n_ext, rp_n_ext;
	logic             empty, full;
	logic [PTR_W-1:0] wp_n, rp_n, raddr;
	logic             notice_n, mem_we, rd_sel, evt;
	stat_t            stat;

	assign adv_s1    = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = valid_s1 && !adv_s1;
	assign accept    = cmd_valid && !cmd_stall;

	// ring length in use, clamped to the legal range
	always_comb begin
		bs_ext = LEN_W'(size_q);
		if (bs_ext < LEN_MIN) begin
			len = LEN_MIN;
		end else if (bs_ext > LEN_MAX) begin
			len = LEN_MAX;
		end else begin
			len = bs_ext;
		end
	end

	assign wp_ext  = LEN_W'(wp_q);
	assign rp_ext  = LEN_W'(rp_q);
	assign wp_inc  = wp_ext + LEN_W'(1);
	assign rp_inc  = rp_ext + LEN_W'(1);
	assign wp_wrap = (wp_inc == len) ? '0 : wp_inc;
	assign rp_wrap = (rp_inc == len) ? '0 : rp_inc;
	assign empty   = (wp_q == rp_q);
	assign full    = (wp_wrap == rp_ext);
	assign cnt_now = (wp_ext >= rp_ext) ? wp_ext - rp_ext : wp_ext + len - rp_ext;

	// peek offset wraps at most once since it stays below the count
	assign peek_sum  = rp_ext + LEN_W'(peek_index);
	assign peek_addr = (peek_sum >= len) ? peek_sum - len : peek_sum;

	always_comb begin
		wp_n     = wp_q;
		rp_n     = rp_q;
		notice_n = notice_q;
		mem_we   = 1'b0;
		rd_sel   = 1'b0;
		evt      = 1'b0;
		stat     = ST_OK;
		raddr    = rp_q;
		case (cmd_t'(command))
			CMD_WRITE: begin
				if (full) begin
					stat = ST_FULL;
				end else begin
					mem_we = 1'b1;
					wp_n   = wp_wrap[PTR_W-1:0];
					if (!notice_q) begin
						notice_n = 1'b1;
						evt      = 1'b1;
					end
				end
			end
			CMD_READ: begin
				if (empty) begin
					stat     = ST_EMPTY;
					notice_n = 1'b0;
				end else begin
					rd_sel = 1'b1;
					rp_n   = rp_wrap[PTR_W-1:0];
				end
			end
			CMD_PEEK: begin
				raddr = peek_addr[PTR_W-1:0];
				if (empty) begin
					stat = ST_EMPTY;
				end else if (LEN_W'(peek_index) >= cnt_now) begin
					stat = ST_BAD_INDEX;
				end else begin
					rd_sel = 1'b1;
				end
			end
			CMD_QUERY: begin
				if (empty) begin
					notice_n = 1'b0;
				end
			end
			CMD_CLEAR: begin
				wp_n     = '0;
				rp_n     = '0;
				notice_n = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign wp_n_ext = LEN_W'(wp_n);
	assign rp_n_ext = LEN_W'(rp_n);
	assign cnt_next = (wp_n_ext >= rp_n_ext) ? wp_n_ext - rp_n_ext
	                                         : wp_n_ext + len - rp_n_ext;

	brfp_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (accept && mem_we),
		.waddr(wp_q),
		.wdata(write_data),
		.re   (accept),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= SIZE_RESET;
			wp_q     <= '0;
			rp_q     <= '0;
			notice_q <= 1'b0;
		end else if (cfg_write_en) begin
			size_q   <= buffer_size;
			wp_q     <= '0;
			rp_q     <= '0;
			notice_q <= 1'b0;
		end else if (accept) begin
			wp_q     <= wp_n;
			rp_q     <= rp_n;
			notice_q <= notice_n;
		end
	end

	// stage 1: ram read in flight, loads when empty or when it moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1 || !valid_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= stat;
			rd_sel_s1 <= rd_sel;
			count_s1  <= cnt_next[CNT_W-1:0];
			free_s1   <= CNT_W'(len - LEN_W'(1) - cnt_next);
			event_s1  <= evt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			status_q    <= status_s1;
			read_data_q <= rd_sel_s1 ? ram_rdata : '0;
			count_q     <= count_s1;
			free_q      <= free_s1;
			event_q     <= event_s1;
		end
	end

	assign rsp_valid          = rsp_valid_q;
	assign status             = status_q;
	assign read_data          = read_data_q;
	assign data_count         = count_q;
	assign free_count         = free_q;
	assign data_arrived_event = event_q;

endmodule
`default_nettype wire

// File: src/brfp_checker.sv
`default_nettype none
`include "assert_macros.svh"
module brfp_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        cmd_valid,
	input wire logic                        cmd_stall,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_stall,
	input wire logic [brfp_pkg::STAT_W-1:0] status,
	input wire logic [brfp_pkg::DATA_W-1:0] read_data,
	input wire logic [brfp_pkg::CNT_W-1:0]  data_count,
	input wire logic                        data_arrived_event
);

	import brfp_pkg::*;

	// a taken command must show a response once the ram read stage and the output register have loaded
	`CHK_ASSERT(a_rsp_latency, clk, arst_n, cmd_valid && !cmd_stall |=> ##1 rsp_valid)

	// failed accesses return zero data
	`CHK_ASSERT(a_zero_on_fail, clk, arst_n, rsp_valid && status != ST_OK |-> read_data == '0)

	// the first-data notice only comes with a stored byte
	`CHK_ASSERT(a_event_ok, clk, arst_n, rsp_valid && data_arrived_event |-> status == ST_OK && data_count != '0)

	`CHK_STABLE(a_count_hold, clk, arst_n, rsp_valid && rsp_stall, data_count)

endmodule

bind byte_ring_fifo_with_peek_top brfp_checker u_brfp_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.cmd_valid         (cmd_valid),
	.cmd_stall         (cmd_stall),
	.rsp_valid         (rsp_valid),
	.rsp_stall         (rsp_stall),
	.status            (status),
	.read_data         (read_data),
	.data_count        (data_count),
	.data_arrived_event(data_arrived_event)
);
`default_nettype wire

// File: sim/tb_byte_ring_fifo_with_peek_top.sv
`timescale 1ns / 100ps
module tb_byte_ring_fifo_with_peek_top;
	import brfp_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;
	localparam int MAX_CYCLES   = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASES       = 10;
	localparam int PHASE_BEATS  = 45;

	typedef struct packed {
		stat_t              st;
		logic [DATA_W-1:0]  rdata;
		logic [CNT_W-1:0]   used;
		logic [CNT_W-1:0]   room;
		logic               arrived;
	} ring_reply_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_write_en;
	logic [SIZE_W-1:0]   buffer_size;
	logic                cmd_valid;
	logic                cmd_stall;
	logic [CMD_W-1:0]    command;
	logic [DATA_W-1:0]   write_data;
	logic [IDX_W-1:0]    peek_index;
	logic                rsp_valid;
	logic                rsp_stall;
	logic [STAT_W-1:0]   status;
	logic [DATA_W-1:0]   read_data;
	logic [CNT_W-1:0]    data_count;
	logic [CNT_W-1:0]    free_count;
	logic                data_arrived_event;

	byte_ring_fifo_with_peek_top dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_write_en       (cfg_write_en),
		.buffer_size        (buffer_size),
		.cmd_valid          (cmd_valid),
		.cmd_stall          (cmd_stall),
		.command            (command),
		.write_data         (write_data),
		.peek_index         (peek_index),
		.rsp_valid          (rsp_valid),
		.rsp_stall          (rsp_stall),
		.status             (status),
		.read_data          (read_data),
		.data_count         (data_count),
		.free_count         (free_count),
		.data_arrived_event (data_arrived_event)
	);

	// predicted ring state
	logic [DATA_W-1:0] ring_mem [DEPTH_DEFAULT];
	int unsigned       ring_len = DEPTH_DEFAULT;
	int unsigned       wr_ptr = 0;
	int unsigned       rd_ptr = 0;
	bit                notice_up = 1'b0;

	ring_reply_t       expected_replies [$];
	bit                quiet = 1'b0;
	int unsigned       cycle_count = 0;
	int unsigned       n_errors = 0;
	int unsigned       n_sent = 0;
	int unsigned       n_checked = 0;
	int unsigned       n_resizes = 0;
	int unsigned       n_full = 0;
	int unsigned       n_empty = 0;
	int unsigned       n_bad_index = 0;
	int unsigned       n_notices = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned ring_used();
		return (wr_ptr + ring_len - rd_ptr) % ring_len;
	endfunction

	function automatic void apply_ring_size(input logic [SIZE_W-1:0] v);
		ring_len = v;
		if (ring_len < 2) ring_len = 2;
		if (ring_len > DEPTH_DEFAULT) ring_len = DEPTH_DEFAULT;
		wr_ptr = 0;
		rd_ptr = 0;
		notice_up = 1'b0;
	endfunction

	function automatic ring_reply_t ring_model_apply(input logic [CMD_W-1:0] cmd,
			input logic [DATA_W-1:0] wd, input logic [IDX_W-1:0] pidx);
		ring_reply_t r;
		int unsigned used;
		bit          is_empty;
		r = '0;
		r.st = ST_OK;
		used = ring_used();
		is_empty = (wr_ptr == rd_ptr);
		case (cmd)
			CMD_WRITE: begin
				if ((wr_ptr + 1) % ring_len == rd_ptr) begin
					r.st = ST_FULL;
				end else begin
					ring_mem[wr_ptr] = wd;
					wr_ptr = (wr_ptr + 1) % ring_len;
					if (!notice_up) begin
						notice_up = 1'b1;
						r.arrived = 1'b1;
					end
				end
			end
			CMD_READ: begin
				if (is_empty) begin
					notice_up = 1'b0;
					r.st = ST_EMPTY;
				end else begin
					r.rdata = ring_mem[rd_ptr];
					rd_ptr = (rd_ptr + 1) % ring_len;
				end
			end
			CMD_PEEK: begin
				// empty wins over a bad offset
				if (is_empty) r.st = ST_EMPTY;
				else if (pidx >= used) r.st = ST_BAD_INDEX;
				else r.rdata = ring_mem[(rd_ptr + pidx) % ring_len];
			end
			CMD_QUERY: begin
				if (is_empty) notice_up = 1'b0;
			end
			CMD_CLEAR: begin
				wr_ptr = 0;
				rd_ptr = 0;
				notice_up = 1'b0;
			end
			default: ;
		endcase
		used = ring_used();
		r.used = CNT_W'(used);
		r.room = CNT_W'(ring_len - 1 - used);
		case (r.st)
			ST_FULL:      n_full++;
			ST_EMPTY:     n_empty++;
			ST_BAD_INDEX: n_bad_index++;
			default: ;
		endcase
		if (r.arrived) n_notices++;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("mismatch in %s at reply %0d: got %0h, expected %0h",
			what, n_checked, got, want);
		n_errors++;
	endtask

	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] wd,
			input logic [IDX_W-1:0] pidx);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd_valid  <= 1'b1;
		command    <= cmd;
		write_data <= wd;
		peek_index <= pidx;
		do @(posedge clk); while (cmd_stall);
		expected_replies.push_back(ring_model_apply(cmd, wd, pidx));
		n_sent++;
	endtask

	// only while nothing is in flight
	task automatic set_ring_size(input logic [SIZE_W-1:0] v);
		cmd_valid <= 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_write_en <= 1'b1;
		buffer_size  <= v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		apply_ring_size(v);
		n_resizes++;
	endtask

	task automatic test_reset_state();
		send_command(CMD_QUERY, 8'h00, 8'h00);
		send_command(CMD_READ, 8'hFF, 8'hFF);
	endtask

	task automatic test_small_ring();
		set_ring_size(9'd4);
		send_command(CMD_PEEK, 8'h00, 8'h00);
		send_command(CMD_WRITE, 8'h00, 8'h00);
		send_command(CMD_WRITE, 8'hFF, 8'h00);
		send_command(CMD_WRITE, 8'hA5, 8'h00);
		send_command(CMD_WRITE, 8'h5A, 8'h00);
		send_command(CMD_PEEK, 8'h00, 8'd0);
		send_command(CMD_PEEK, 8'h00, 8'd2);
		send_command(CMD_PEEK, 8'h00, 8'd3);
		send_command(CMD_PEEK, 8'h00, 8'd255);
		send_command(CMD_READ, 8'h00, 8'h00);
		send_command(CMD_READ, 8'h00, 8'h00);
		send_command(CMD_READ, 8'h00, 8'h00);
		send_command(CMD_READ, 8'h00, 8'h00);
		// empty read dropped the notice, so this write raises it again
		send_command(CMD_WRITE, 8'h3C, 8'h00);
	endtask

	task automatic test_clear_and_spare();
		send_command(CMD_SPARE5, 8'h11, 8'h22);
		send_command(CMD_SPARE6, 8'h33, 8'h44);
		send_command(CMD_SPARE7, 8'h55, 8'h66);
		send_command(CMD_CLEAR, 8'h00, 8'h00);
		send_command(CMD_WRITE, 8'hC3, 8'h00);
	endtask

	task automatic test_size_extremes();
		set_ring_size(9'd0);
		send_command(CMD_WRITE, 8'h81, 8'h00);
		send_command(CMD_WRITE, 8'h7E, 8'h00);
		send_command(CMD_READ, 8'h00, 8'h00);
		set_ring_size(9'd511);
		send_command(CMD_QUERY, 8'h00, 8'h00);
		set_ring_size(9'd1);
		send_command(CMD_QUERY, 8'h00, 8'h00);
	endtask

	task automatic test_random_traffic();
		logic [SIZE_W-1:0] v;
		logic [CMD_W-1:0]  cmd;
		logic [IDX_W-1:0]  pidx;
		int unsigned       r;
		int unsigned       wr_pct;
		int unsigned       rd_pct;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: v = 9'd2;
				1: v = 9'd256;
				2: v = 9'd3;
				3: v = 9'(($urandom_range(4, 40)));
				4: v = 9'd511;
				5: v = 9'd1;
				6: v = 9'(($urandom_range(2, 511)));
				7: v = 9'd17;
				8: v = 9'd0;
				default: v = 9'(($urandom_range(2, 60)));
			endcase
			if (p >= PHASES - 2) quiet = 1'b1;
			set_ring_size(v);
			for (int i = 0; i < PHASE_BEATS; i++) begin
				// fill in the first half, drain in the second
				wr_pct = (i < PHASE_BEATS / 2) ? 60 : 20;
				rd_pct = (i < PHASE_BEATS / 2) ? 15 : 50;
				r = $urandom_range(0, 99);
				if (r < wr_pct) cmd = CMD_WRITE;
				else if (r < wr_pct + rd_pct) cmd = CMD_READ;
				else if (r < 90) cmd = CMD_PEEK;
				else if (r < 94) cmd = CMD_QUERY;
				else if (r < 97) cmd = CMD_CLEAR;
				else begin
					case ($urandom_range(0, 2))
						0: cmd = CMD_SPARE5;
						1: cmd = CMD_SPARE6;
						default: cmd = CMD_SPARE7;
					endcase
				end
				if ($urandom_range(0, 3) == 0) pidx = IDX_W'($urandom_range(0, 255));
				else pidx = IDX_W'($urandom_range(0, ring_used()));
				send_command(cmd, DATA_W'($urandom_range(0, 255)), pidx);
			end
		end
	endtask

	initial begin
		arst_n       <= 1'b0;
		cfg_write_en <= 1'b0;
		buffer_size  <= SIZE_RESET;
		cmd_valid    <= 1'b0;
		command      <= CMD_QUERY;
		write_data   <= '0;
		peek_index   <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_small_ring();
		test_clear_and_spare();
		test_size_extremes();
		test_random_traffic();

		cmd_valid <= 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d commands over %0d ring sizes, %0d replies checked",
			n_sent, n_resizes, n_checked);
		$display("full %0d, empty %0d, bad index %0d, first-data notices %0d",
			n_full, n_empty, n_bad_index, n_notices);
		if (n_errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// response side back-pressure, with calm stretches
	initial begin
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(10, 30)) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : reply_check
		ring_reply_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_replies.size() == 0) begin
				report_mismatch("reply with no command outstanding", status, 0);
			end else begin
				want = expected_replies.pop_front();
				if (status !== want.st) report_mismatch("status", status, want.st);
				if (read_data !== want.rdata) report_mismatch("read_data", read_data, want.rdata);
				if (data_count !== want.used) report_mismatch("data_count", data_count, want.used);
				if (free_count !== want.room) report_mismatch("free_count", free_count, want.room);
				if (data_arrived_event !== want.arrived)
					report_mismatch("data_arrived_event", data_arrived_event, want.arrived);
				n_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLES) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

endmodule

// File: filelist.f
+incdir+src
src/brfp_pkg.sv
src/brfp_ram.sv
src/byte_ring_fifo_with_peek_top.sv
src/brfp_checker.sv
sim/tb_byte_ring_fifo_with_peek_top.sv
